>>> rtl/core/swgc_pkg.sv
// ----------------------------------------------------------------------------
// swgc_pkg
// shared constants, types and the symbol classifier for the sliding window
// c/g fraction block
// ----------------------------------------------------------------------------
package swgc_pkg;

    localparam int WINDOW  = 20;
    localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W  = $clog2(WINDOW + 2);
    localparam int CLASS_W = 2;
    localparam int SYM_W   = 8;
    localparam int TOT_W   = 7;
    localparam int FRAC_W  = 16;
    localparam int STEP_W  = $clog2(FRAC_W + 1);

    typedef enum logic [CLASS_W-1:0] {
        CLS_OTHER = 2'd0,
        CLS_AT    = 2'd1,
        CLS_CG    = 2'd2
    } t_class;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [TOT_W-1:0] num;
        logic [TOT_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } t_div_rsp;

    function automatic t_class classify(input logic [SYM_W-1:0] b);
        t_class c;
        case (b) inside
            "A", "a", "T", "t": c = CLS_AT;
            "C", "c", "G", "g": c = CLS_CG;
            default:            c = CLS_OTHER;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/swgc_ram.sv
// ----------------------------------------------------------------------------
// swgc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module swgc_ram #(
    parameter int WIDTH  = 2,
    parameter int DEPTH  = 20,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/swgc_div.sv
// ----------------------------------------------------------------------------
// swgc_div
// restoring divider, one quotient bit per cycle: floor(num * 2^16 / den)
// for num < den
// ----------------------------------------------------------------------------
module swgc_div
    import swgc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    logic [TOT_W-1:0]  r_rem, n_rem;
    logic [TOT_W-1:0]  r_den, n_den;
    logic [FRAC_W-1:0] r_quot, n_quot;
    logic              r_done, n_done;
    logic [TOT_W:0]    shifted;
    logic              fits;

    assign shifted = {r_rem, 1'b0};
    assign fits    = (shifted >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = i_req.num;
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem  = fits ? TOT_W'(shifted - {1'b0, r_den}) : TOT_W'(shifted);
            n_quot = {r_quot[FRAC_W-2:0], fits};
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(FRAC_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

>>> rtl/core/sliding_window_gc_fraction.sv
// ----------------------------------------------------------------------------
// sliding_window_gc_fraction
// running c/g and a/t counts over the last WINDOW bytes, with c/g fraction
// ----------------------------------------------------------------------------
// Each byte is classed as A/T, C/G or other (case-insensitive); the classes
// of the last WINDOW bytes live in a small RAM that is read, then rewritten
// with the new class, while the running counts are adjusted. From byte
// WINDOW+1 on, each item yields cg_total, at_total and cg_fraction =
// floor(cg*65536/(cg+at)), zero when either count is zero. An item passes
// S_IDLE (accept with RAM read) and S_UPDATE (count update) when no result
// is due; when a result is due and a count is zero it adds S_OUT to load the
// result register, and when the fraction is computed it goes through S_DIV,
// where the divider produces one quotient bit per cycle and then hands over
// its quotient, before S_OUT. Loading the result waits while the previous
// result is still held and stalled. The result register lets the next item
// enter while a result waits to be taken.
// ----------------------------------------------------------------------------
module sliding_window_gc_fraction
    import swgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [SYM_W-1:0]  i_symbol,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [FRAC_W-1:0] o_cg_fraction,
    output logic [TOT_W-1:0]  o_cg_total,
    output logic [TOT_W-1:0]  o_at_total
);

    t_state            r_state, n_state;
    t_class            r_cls, n_cls;
    logic [PTR_W-1:0]  r_wr_pos, n_wr_pos;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [TOT_W-1:0]  r_cg, n_cg;
    logic [TOT_W-1:0]  r_at, n_at;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic              r_out_valid, n_out_valid;
    logic [FRAC_W-1:0] r_out_frac, n_out_frac;
    logic [TOT_W-1:0]  r_out_cg, n_out_cg;
    logic [TOT_W-1:0]  r_out_at, n_out_at;

    logic [CLASS_W-1:0] ram_rdata;
    logic               ram_we;
    t_class             old_cls;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    swgc_ram #(
        .WIDTH (CLASS_W),
        .DEPTH (WINDOW),
        .ADDR_W(PTR_W)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wr_pos),
        .i_wdata(r_cls),
        .i_raddr(r_wr_pos),
        .o_rdata(ram_rdata)
    );

    swgc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // entries not yet written since reset read as other
    assign old_cls = (r_fill >= FILL_W'(WINDOW)) ? t_class'(ram_rdata) : CLS_OTHER;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        logic [TOT_W-1:0] cg_t;
        logic [TOT_W-1:0] at_t;
        n_state     = r_state;
        n_cls       = r_cls;
        n_wr_pos    = r_wr_pos;
        n_fill      = r_fill;
        n_cg        = r_cg;
        n_at        = r_at;
        n_frac      = r_frac;
        n_out_frac  = r_out_frac;
        n_out_cg    = r_out_cg;
        n_out_at    = r_out_at;
        n_out_valid = (r_out_valid && !i_stall) ? 1'b0 : r_out_valid;
        ram_we      = 1'b0;
        div_req     = '{start: 1'b0, num: r_cg, den: TOT_W'(r_cg + r_at)};
        cg_t        = r_cg;
        at_t        = r_at;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cls   = classify(i_symbol);
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (old_cls == CLS_AT && r_at != '0) begin
                    at_t = r_at - 1'b1;
                end else if (old_cls == CLS_CG && r_cg != '0) begin
                    cg_t = r_cg - 1'b1;
                end
                if (r_cls == CLS_AT) begin
                    at_t = at_t + 1'b1;
                end else if (r_cls == CLS_CG) begin
                    cg_t = cg_t + 1'b1;
                end
                n_cg     = cg_t;
                n_at     = at_t;
                ram_we   = 1'b1;
                n_wr_pos = (r_wr_pos == PTR_W'(WINDOW - 1)) ? '0 : r_wr_pos + 1'b1;
                if (r_fill <= FILL_W'(WINDOW)) begin
                    n_fill = r_fill + 1'b1;
                end
                if (n_fill > FILL_W'(WINDOW)) begin
                    if (cg_t == '0 || at_t == '0) begin
                        n_frac  = '0;
                        n_state = S_OUT;
                    end else begin
                        div_req = '{start: 1'b1, num: cg_t, den: TOT_W'(cg_t + at_t)};
                        n_state = S_DIV;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_frac  = div_rsp.quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_frac  = r_frac;
                    n_out_cg    = r_cg;
                    n_out_at    = r_at;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_pos    <= '0;
            r_fill      <= '0;
            r_cg        <= '0;
            r_at        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_pos    <= n_wr_pos;
            r_fill      <= n_fill;
            r_cg        <= n_cg;
            r_at        <= n_at;
            r_out_valid <= n_out_valid;
        end
        r_cls      <= n_cls;
        r_frac     <= n_frac;
        r_out_frac <= n_out_frac;
        r_out_cg   <= n_out_cg;
        r_out_at   <= n_out_at;
    end

    assign o_valid       = r_out_valid;
    assign o_cg_fraction = r_out_frac;
    assign o_cg_total    = r_out_cg;
    assign o_at_total    = r_out_at;

endmodule

>>> tb/gc_window_checker.sv
// ----------------------------------------------------------------------------
// gc_window_checker
// Watches the symbol and result channels of sliding_window_gc_fraction.
// Every accepted symbol moves a private copy of the class window and its
// running counts. Once the warm-up is over, the symbol also queues the
// c/g fraction and both counts that it must produce. Every accepted result
// is checked field by field against the oldest queued expectation.
// ----------------------------------------------------------------------------
module gc_window_checker
    import swgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sym_valid,
    input  logic              i_sym_stall,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic              i_res_valid,
    input  logic              i_res_stall,
    input  logic [FRAC_W-1:0] i_cg_fraction,
    input  logic [TOT_W-1:0]  i_cg_total,
    input  logic [TOT_W-1:0]  i_at_total,
    output int                o_mismatches,
    output int                o_outstanding,
    output int                o_results_checked
);

    typedef struct packed {
        logic [FRAC_W-1:0] frac;
        logic [TOT_W-1:0]  cg;
        logic [TOT_W-1:0]  at;
    } t_gc_result;

    t_gc_result       gc_expected_q[$];
    t_class           class_ring[WINDOW];
    logic [TOT_W-1:0] cg_count;
    logic [TOT_W-1:0] at_count;
    int unsigned      fill_level;
    int unsigned      ring_pos;

    initial begin
        o_mismatches      = 0;
        o_outstanding     = 0;
        o_results_checked = 0;
    end

    function automatic t_class base_class(input logic [SYM_W-1:0] b);
        case (b)
            "A", "a", "T", "t": return CLS_AT;
            "C", "c", "G", "g": return CLS_CG;
            default:            return CLS_OTHER;
        endcase
    endfunction

    task automatic clear_window();
        for (int k = 0; k < WINDOW; k++) class_ring[k] = CLS_OTHER;
        cg_count   = '0;
        at_count   = '0;
        fill_level = 0;
        ring_pos   = 0;
        gc_expected_q.delete();
    endtask

    task automatic advance_window(input logic [SYM_W-1:0] sym);
        t_class      incoming;
        t_class      leaving;
        t_gc_result  r;
        logic [31:0] scaled;
        incoming = base_class(sym);
        leaving  = class_ring[ring_pos];
        if (leaving == CLS_AT && at_count != 0) begin
            at_count = at_count - 1'b1;
        end else if (leaving == CLS_CG && cg_count != 0) begin
            cg_count = cg_count - 1'b1;
        end
        class_ring[ring_pos] = incoming;
        if (incoming == CLS_AT) begin
            at_count = at_count + 1'b1;
        end else if (incoming == CLS_CG) begin
            cg_count = cg_count + 1'b1;
        end
        ring_pos = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
        if (fill_level <= WINDOW) fill_level++;
        if (fill_level > WINDOW) begin
            // fraction forced to zero when either side is empty
            if (cg_count == 0 || at_count == 0) begin
                r.frac = '0;
            end else begin
                scaled = (32'(cg_count) << FRAC_W) / (32'(cg_count) + 32'(at_count));
                r.frac = scaled[FRAC_W-1:0];
            end
            r.cg = cg_count;
            r.at = at_count;
            gc_expected_q.push_back(r);
        end
    endtask

    task automatic compare_result();
        t_gc_result want;
        if (gc_expected_q.size() == 0) begin
            $error("result item with no expectation: frac %0d cg %0d at %0d",
                   i_cg_fraction, i_cg_total, i_at_total);
            o_mismatches++;
        end else begin
            want = gc_expected_q.pop_front();
            o_results_checked++;
            if (i_cg_fraction !== want.frac) begin
                $error("cg_fraction mismatch: expected %0d, actual %0d",
                       want.frac, i_cg_fraction);
                o_mismatches++;
            end
            if (i_cg_total !== want.cg) begin
                $error("cg_total mismatch: expected %0d, actual %0d", want.cg, i_cg_total);
                o_mismatches++;
            end
            if (i_at_total !== want.at) begin
                $error("at_total mismatch: expected %0d, actual %0d", want.at, i_at_total);
                o_mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_window();
        end else begin
            if (i_res_valid && !i_res_stall) compare_result();
            if (i_sym_valid && !i_sym_stall) advance_window(i_symbol);
        end
        o_outstanding <= gc_expected_q.size();
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for sliding_window_gc_fraction. A directed warm-up
// with an all c/g window is sent first. A random mix follows: base streams
// with a varying c/g bias, single-class runs long enough to fill the window,
// raw random bytes and near-miss letters. The sender works in bursts and the
// receiver stalls on a changing pattern. Checking is done by gc_window_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import swgc_pkg::*;

    localparam int ITEM_TARGET = 1050;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [SYM_W-1:0]  i_symbol = '0;
    logic              i_stall = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [FRAC_W-1:0] o_cg_fraction;
    logic [TOT_W-1:0]  o_cg_total;
    logic [TOT_W-1:0]  o_at_total;

    int mismatches;
    int outstanding;
    int results_checked;
    int symbols_sent = 0;
    int burst_left = 1;
    int stall_mode = 0;
    int stall_left = 0;

    logic [7:0] cg_letters[4] = '{"C", "c", "G", "g"};
    logic [7:0] at_letters[4] = '{"A", "a", "T", "t"};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sliding_window_gc_fraction DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_symbol      (i_symbol),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_cg_fraction (o_cg_fraction),
        .o_cg_total    (o_cg_total),
        .o_at_total    (o_at_total)
    );

    gc_window_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_sym_valid       (i_valid),
        .i_sym_stall       (o_stall),
        .i_symbol          (i_symbol),
        .i_res_valid       (o_valid),
        .i_res_stall       (i_stall),
        .i_cg_fraction     (o_cg_fraction),
        .i_cg_total        (o_cg_total),
        .i_at_total        (o_at_total),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding),
        .o_results_checked (results_checked)
    );

    // receiver stall pattern: free flow, random stalls, or long stall stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(10, 80);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 2) == 0);
                default: i_stall <= ((stall_left % 16) < 9);
            endcase
        end
    end

    function automatic logic [7:0] other_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b inside {"A", "a", "T", "t", "C", "c", "G", "g"});
        return b;
    endfunction

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic send_symbol(input logic [7:0] sym);
        i_valid  <= 1'b1;
        i_symbol <= sym;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        symbols_sent++;
        pace_sender();
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin
        int         seg;
        int         len;
        int         cg_bias;
        int         run_class;
        bit         paused_once;
        logic [7:0] sym;
        paused_once = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // warm-up with an all c/g window, then both sides and the byte extremes
        for (int n = 0; n < WINDOW + 1; n++) send_symbol(cg_letters[n % 4]);
        send_symbol("a");
        send_symbol("T");
        send_symbol(8'h00);
        send_symbol(8'hFF);

        while (symbols_sent < ITEM_TARGET) begin
            if (!paused_once && symbols_sent >= ITEM_TARGET / 2) begin
                drain_results();
                paused_once = 1'b1;
            end
            seg = $urandom_range(0, 9);
            case (seg)
                0, 1, 2, 3, 4: begin
                    len     = $urandom_range(10, 60);
                    cg_bias = $urandom_range(0, 4) == 0 ? 100 * $urandom_range(0, 1)
                                                        : $urandom_range(0, 100);
                    for (int n = 0; n < len; n++) begin
                        if ($urandom_range(0, 9) == 0) sym = other_byte();
                        else if ($urandom_range(0, 99) < cg_bias)
                            sym = cg_letters[$urandom_range(0, 3)];
                        else sym = at_letters[$urandom_range(0, 3)];
                        send_symbol(sym);
                    end
                end
                5, 6: begin
                    // single-class run fills the window with one side or none
                    len       = $urandom_range(WINDOW, 2 * WINDOW);
                    run_class = $urandom_range(0, 2);
                    for (int n = 0; n < len; n++) begin
                        case (run_class)
                            0:       sym = cg_letters[$urandom_range(0, 3)];
                            1:       sym = at_letters[$urandom_range(0, 3)];
                            default: sym = other_byte();
                        endcase
                        send_symbol(sym);
                    end
                end
                7, 8: begin
                    len = $urandom_range(5, 30);
                    for (int n = 0; n < len; n++) send_symbol(8'($urandom_range(0, 255)));
                end
                default: begin
                    // letters with one bit flipped
                    len = $urandom_range(5, 20);
                    for (int n = 0; n < len; n++) begin
                        sym = ($urandom_range(0, 1) != 0) ? cg_letters[$urandom_range(0, 3)]
                                                          : at_letters[$urandom_range(0, 3)];
                        send_symbol(sym ^ (8'h01 << $urandom_range(0, 7)));
                    end
                end
            endcase
        end

        drain_results();
        repeat (40) @(posedge i_clk);

        $display("covered %0d symbols: warm-up, one-sided and empty windows, random bytes",
                 symbols_sent);
        $display("%0d results compared field by field", results_checked);
        if (outstanding != 0) begin
            $error("%0d expected results never arrived", outstanding);
        end
        if (mismatches == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/core/swgc_pkg.sv
rtl/core/swgc_ram.sv
rtl/core/swgc_div.sv
rtl/core/sliding_window_gc_fraction.sv
tb/gc_window_checker.sv
tb/tb_top.sv
